@@ hdl/kst_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed score table with max query.
// ---------------------------------------------------------------------------
package kst_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_MAX    = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        key;
    logic signed [31:0] score;
  } in_item_t;

  typedef struct packed {
    logic        success;
    logic        empty_res;
    logic [63:0] max_key;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] score;
  } entry_t;

endpackage

@@ hdl/keyed_score_table_max.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_score_table_max
// Unsorted keyed table of signed scores with insert, delete, search and
// max-score query.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying one operation item (operation,
//           key, score). in_ready is high only while the block is idle.
//   out_* : valid/ready channel carrying one result item per input item
//           (success, empty_res, max_key), held in an output register.
// Timing: every operation scans all entries in use through the single
//   memory read port, one entry per cycle, with one shared key-match and
//   score-compare unit. The next item is accepted in the cycle after the
//   result is loaded.
// Reset: rst_n (synchronous) empties the table; memory contents are not
//   cleared since only slots below the entry count are ever read.
// Stall: a waiting result does not block the next scan; the block only
//   holds in its final step if the previous result is still not taken.
// ---------------------------------------------------------------------------
module keyed_score_table_max #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kst_pkg::out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  kst_pkg::entry_t wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  kst_pkg::entry_t rd_data;

  kst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  kst_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ hdl/kst_store.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_store
// Entry memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module kst_store #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  kst_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output kst_pkg::entry_t rd_data
);

  kst_pkg::entry_t mem [CAPACITY];
  kst_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/kst_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_ctrl
// Sequencer with one shared key-match / score-compare unit that scans the
// stored entries one per cycle, then updates the table and the result.
// ---------------------------------------------------------------------------
module kst_ctrl #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kst_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kst_pkg::out_item_t  out_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output kst_pkg::entry_t     wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  kst_pkg::entry_t     rd_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                dv_r, dv_nxt;
  logic [AW-1:0]       didx_r, didx_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  kst_pkg::entry_t     best_r, best_nxt;
  kst_pkg::entry_t     last_r, last_nxt;
  kst_pkg::in_item_t   req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  kst_pkg::out_item_t  out_data_r, out_data_nxt;

  logic key_hit;
  logic score_gt;
  logic not_full;

  // the shared compare unit
  assign key_hit  = (rd_data.key == req_r.key);
  assign score_gt = (rd_data.score > best_r.score);
  assign not_full = (count_r < CW'(CAPACITY));

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_addr   = idx_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    dv_nxt        = dv_r;
    didx_nxt      = didx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    best_nxt      = best_r;
    last_nxt      = last_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = '{key: req_r.key, score: req_r.score};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          dv_nxt    = 1'b0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en    = (idx_r < count_r);
        dv_nxt   = rd_en;
        didx_nxt = idx_r[AW-1:0];
        if (rd_en) begin
          idx_nxt = idx_r + CW'(1);
        end
        // data read in the previous cycle comes back now
        if (dv_r) begin
          if (key_hit && !found_r) begin
            found_nxt = 1'b1;
            slot_nxt  = didx_r;
          end
          if (CW'(didx_r) == count_r - CW'(1)) begin
            last_nxt = rd_data;
          end
          // strict compare keeps the lowest slot on a tie
          if (didx_r == '0 || score_gt) begin
            best_nxt = rd_data;
          end
        end
        if (!rd_en && !dv_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
          unique case (req_r.operation)
            kst_pkg::OP_INSERT: begin
              if (!found_r && not_full) begin
                wr_en                = 1'b1;
                count_nxt            = count_r + CW'(1);
                out_data_nxt.success = 1'b1;
              end
            end
            kst_pkg::OP_DELETE: begin
              if (found_r) begin
                wr_en                = 1'b1;
                wr_addr              = slot_r;
                wr_data              = last_r;
                count_nxt            = count_r - CW'(1);
                out_data_nxt.success = 1'b1;
              end
            end
            kst_pkg::OP_MAX: begin
              if (count_r == '0) begin
                out_data_nxt.empty_res = 1'b1;
              end else begin
                out_data_nxt.success = 1'b1;
                out_data_nxt.max_key = best_r.key;
              end
            end
            default: begin
              out_data_nxt.success = found_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    didx_r     <= didx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    best_r     <= best_nxt;
    last_r     <= last_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/kst_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kst_checker
// Port-level checks for the keyed score table, bound to the top level.
// ---------------------------------------------------------------------------
module kst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input kst_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.success && out_data.empty_res))
    else $error("success and empty both set");

  a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.max_key == '0)
    else $error("nonzero key on empty result");

endmodule

bind keyed_score_table_max kst_checker u_kst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
